### hw/rtl/dic_pkg.sv
// Shared types and constants for the dual interrupt controller.
// Holds action codes, register map word offsets and configuration indexes.
// No dependencies.
`default_nettype none

package dic_pkg;

	// Bus action carried by each input transfer
	localparam logic [1:0] ACT_SAMPLE = 2'd0;
	localparam logic [1:0] ACT_READ   = 2'd1;
	localparam logic [1:0] ACT_WRITE  = 2'd2;

	// Register map, as word offsets (byte offset bits [5:2])
	localparam logic [3:0] OFS_IRQ_SOURCE   = 4'h0; // 0x00
	localparam logic [3:0] OFS_IRQ_MASK     = 4'h1; // 0x04
	localparam logic [3:0] OFS_IRQ_CLEAR    = 4'h2; // 0x08
	localparam logic [3:0] OFS_IRQ_MODE     = 4'h3; // 0x0C
	localparam logic [3:0] OFS_IRQ_POLARITY = 4'h4; // 0x10
	localparam logic [3:0] OFS_IRQ_STATUS   = 4'h5; // 0x14
	localparam logic [3:0] OFS_FIQ_SOURCE   = 4'h8; // 0x20
	localparam logic [3:0] OFS_FIQ_MASK     = 4'h9; // 0x24
	localparam logic [3:0] OFS_FIQ_CLEAR    = 4'hA; // 0x28
	localparam logic [3:0] OFS_FIQ_MODE     = 4'hB; // 0x2C
	localparam logic [3:0] OFS_FIQ_POLARITY = 4'hC; // 0x30
	localparam logic [3:0] OFS_FIQ_STATUS   = 4'hD; // 0x34

	// Configuration register indexes
	localparam logic [2:0] CFG_IRQ_EDGE_MODE  = 3'd0;
	localparam logic [2:0] CFG_IRQ_ACTIVE_LOW = 3'd1;
	localparam logic [2:0] CFG_FIQ_EDGE_MODE  = 3'd2;
	localparam logic [2:0] CFG_FIQ_ACTIVE_LOW = 3'd3;

	localparam int DATA_W = 32;
	localparam int CFG_INDEX_W = 3;
	localparam int LINE_INDEX_W = 5;

	// Per-set control for one processed transfer
	typedef struct packed {
		logic fire;     // commit this transfer's state update
		logic wr_mask;  // bus write to the mask register
		logic wr_clear; // bus write to the clear register
	} set_ctl_t;

endpackage

`default_nettype wire

### hw/rtl/dual_interrupt_controller_top.sv
// Top level of the dual (IRQ and FIQ) interrupt controller.
// Depends on dic_pkg and dic_set.
//
// Usage:
//  - Input channel (in_valid / in_stall): each transfer samples all source
//    lines (line_levels) and may carry one bus read or write (action,
//    reg_offset, write_value).
//  - Output channel (out_valid / out_stall): one result per input transfer,
//    in order: read data, IRQ and FIQ request, lowest pending IRQ line.
//  - Configuration port (cfg_write, cfg_index, cfg_data): sets per-line
//    trigger mode and polarity of both sets; write only while idle.
//  - The item sits in the input register while the per-line logic and encoder
//    run; its result is then captured in the result register.
//  - Throughput is one transfer per cycle while the receiver does not stall;
//    the per-bit logic and the encoder lie between the two registers.
//  - When the receiver stalls, the result register holds and the input
//    register holds one more item; in_stall rises only when both are full.
//  - Reset clears masks, edge latches, the previous-level register and the
//    configuration; the first sample then sees a line already high as a
//    rising edge.
`default_nettype none

module dual_interrupt_controller_top #(
	parameter int LINE_COUNT = 32
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	// input channel
	input  wire logic                                in_valid,
	output logic                                     in_stall,
	input  wire logic [1:0]                          action,
	input  wire logic [5:0]                          reg_offset,
	input  wire logic [dic_pkg::DATA_W-1:0]          write_value,
	input  wire logic [dic_pkg::DATA_W-1:0]          line_levels,
	// output channel
	output logic                                     out_valid,
	input  wire logic                                out_stall,
	output logic      [dic_pkg::DATA_W-1:0]          read_value,
	output logic                                     irq_request,
	output logic                                     fiq_request,
	output logic      [dic_pkg::LINE_INDEX_W-1:0]    lowest_pending,
	// configuration port
	input  wire logic                                cfg_write,
	input  wire logic [dic_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  wire logic [dic_pkg::DATA_W-1:0]          cfg_data
);

	// Configuration registers, only the implemented lines are kept
	logic [LINE_COUNT-1:0] irq_edge_mode_q;
	logic [LINE_COUNT-1:0] irq_active_low_q;
	logic [LINE_COUNT-1:0] fiq_edge_mode_q;
	logic [LINE_COUNT-1:0] fiq_active_low_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			irq_edge_mode_q <= '0;
			irq_active_low_q <= '0;
			fiq_edge_mode_q <= '0;
			fiq_active_low_q <= '0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				dic_pkg::CFG_IRQ_EDGE_MODE:  irq_edge_mode_q <= cfg_data[LINE_COUNT-1:0];
				dic_pkg::CFG_IRQ_ACTIVE_LOW: irq_active_low_q <= cfg_data[LINE_COUNT-1:0];
				dic_pkg::CFG_FIQ_EDGE_MODE:  fiq_edge_mode_q <= cfg_data[LINE_COUNT-1:0];
				dic_pkg::CFG_FIQ_ACTIVE_LOW: fiq_active_low_q <= cfg_data[LINE_COUNT-1:0];
				default: ; // indexes beyond the list are dropped
			endcase
		end
	end

	// Input register stage
	logic                       s1_valid_q;
	logic [1:0]                 action_s1;
	logic [3:0]                 word_s1;
	logic [LINE_COUNT-1:0]      wdata_s1;
	logic [LINE_COUNT-1:0]      levels_s1;
	logic                       fire;
	logic                       in_accept;
	logic                       out_valid_q;

	// Advance when the result register is empty or drains this cycle
	assign fire = s1_valid_q && (!out_valid_q || !out_stall);
	assign in_stall = s1_valid_q && !fire;
	assign in_accept = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_accept) begin
			s1_valid_q <= 1'b1;
		end else if (fire) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			action_s1 <= action;
			word_s1 <= reg_offset[5:2];
			wdata_s1 <= write_value[LINE_COUNT-1:0];
			levels_s1 <= line_levels[LINE_COUNT-1:0];
		end
	end

	// Previous sampled levels, advance once per processed transfer
	logic [LINE_COUNT-1:0] last_levels_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_levels_q <= '0;
		end else if (fire) begin
			last_levels_q <= levels_s1;
		end
	end

	// Bus write decode per set
	logic              is_write;
	dic_pkg::set_ctl_t irq_ctl;
	dic_pkg::set_ctl_t fiq_ctl;

	always_comb begin
		is_write = (action_s1 == dic_pkg::ACT_WRITE);
		irq_ctl.fire = fire;
		irq_ctl.wr_mask = is_write && (word_s1 == dic_pkg::OFS_IRQ_MASK);
		irq_ctl.wr_clear = is_write && (word_s1 == dic_pkg::OFS_IRQ_CLEAR);
		fiq_ctl.fire = fire;
		fiq_ctl.wr_mask = is_write && (word_s1 == dic_pkg::OFS_FIQ_MASK);
		fiq_ctl.wr_clear = is_write && (word_s1 == dic_pkg::OFS_FIQ_CLEAR);
	end

	logic [LINE_COUNT-1:0] irq_pend;
	logic [LINE_COUNT-1:0] irq_enable;
	logic [LINE_COUNT-1:0] irq_status;
	logic [LINE_COUNT-1:0] fiq_pend;
	logic [LINE_COUNT-1:0] fiq_enable;
	logic [LINE_COUNT-1:0] fiq_status;

	dic_set #(
		.LINE_COUNT(LINE_COUNT)
	) u_irq_set (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (irq_ctl),
		.levels     (levels_s1),
		.last_levels(last_levels_q),
		.edge_mode  (irq_edge_mode_q),
		.active_low (irq_active_low_q),
		.wdata      (wdata_s1),
		.pend_pre   (irq_pend),
		.enable_q   (irq_enable),
		.status_post(irq_status)
	);

	dic_set #(
		.LINE_COUNT(LINE_COUNT)
	) u_fiq_set (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (fiq_ctl),
		.levels     (levels_s1),
		.last_levels(last_levels_q),
		.edge_mode  (fiq_edge_mode_q),
		.active_low (fiq_active_low_q),
		.wdata      (wdata_s1),
		.pend_pre   (fiq_pend),
		.enable_q   (fiq_enable),
		.status_post(fiq_status)
	);

	// Read mux: values include this sample but precede this transfer's write
	logic [LINE_COUNT-1:0] rd_lines;
	logic [dic_pkg::DATA_W-1:0] rd_data;

	always_comb begin
		unique case (word_s1)
			dic_pkg::OFS_IRQ_SOURCE:   rd_lines = irq_pend;
			dic_pkg::OFS_IRQ_MASK:     rd_lines = irq_enable;
			dic_pkg::OFS_IRQ_MODE:     rd_lines = irq_edge_mode_q;
			dic_pkg::OFS_IRQ_POLARITY: rd_lines = irq_active_low_q;
			dic_pkg::OFS_IRQ_STATUS:   rd_lines = irq_pend & irq_enable;
			dic_pkg::OFS_FIQ_SOURCE:   rd_lines = fiq_pend;
			dic_pkg::OFS_FIQ_MASK:     rd_lines = fiq_enable;
			dic_pkg::OFS_FIQ_MODE:     rd_lines = fiq_edge_mode_q;
			dic_pkg::OFS_FIQ_POLARITY: rd_lines = fiq_active_low_q;
			dic_pkg::OFS_FIQ_STATUS:   rd_lines = fiq_pend & fiq_enable;
			default:                   rd_lines = '0; // clear and unmapped read 0
		endcase
		rd_data = (action_s1 == dic_pkg::ACT_READ) ? dic_pkg::DATA_W'(rd_lines) : '0;
	end

	// Lowest set IRQ status line: isolate the lowest one, then OR-encode it
	logic [LINE_COUNT-1:0]             irq_lowest_onehot;
	logic [dic_pkg::LINE_INDEX_W-1:0]  irq_lowest_idx;

	always_comb begin
		irq_lowest_onehot = irq_status & (~irq_status + 1'b1);
		irq_lowest_idx = '0;
		for (int b = 0; b < dic_pkg::LINE_INDEX_W; b++) begin
			for (int i = 0; i < LINE_COUNT; i++) begin
				if (((i >> b) & 1) != 0) begin
					irq_lowest_idx[b] = irq_lowest_idx[b] | irq_lowest_onehot[i];
				end
			end
		end
	end

	// Result register
	logic [dic_pkg::DATA_W-1:0]       read_value_q;
	logic                             irq_request_q;
	logic                             fiq_request_q;
	logic [dic_pkg::LINE_INDEX_W-1:0] lowest_pending_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			read_value_q <= rd_data;
			irq_request_q <= |irq_status;
			fiq_request_q <= |fiq_status;
			lowest_pending_q <= irq_lowest_idx;
		end
	end

	assign out_valid = out_valid_q;
	assign read_value = read_value_q;
	assign irq_request = irq_request_q;
	assign fiq_request = fiq_request_q;
	assign lowest_pending = lowest_pending_q;

`ifndef NO_ASSERTIONS
	// A nonzero lowest line only comes with an IRQ request
	a_lowest_needs_request: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (lowest_pending_q != '0) |-> irq_request_q)
		else $error("lowest_pending set without irq_request");

	// Non-read transfers return zero read data
	a_nonread_zero: assert property (@(posedge clk) disable iff (!arst_n)
		fire && (action_s1 != dic_pkg::ACT_READ) |=> (read_value_q == '0))
		else $error("read data nonzero for a non-read transfer");

	// A held input item is not dropped
	a_s1_held: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q && !fire |=> s1_valid_q)
		else $error("input register item lost while stalled");

	// A processed transfer always shows up at the output
	a_fire_result: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> out_valid_q)
		else $error("processed transfer did not produce a result");
`endif

endmodule

`default_nettype wire

### hw/rtl/dic_set.sv
// One interrupt register set: edge latches, enable mask, pending and status.
// Instantiated once for IRQ and once for FIQ; uses dic_pkg::set_ctl_t.
`default_nettype none

module dic_set #(
	parameter int LINE_COUNT = 32
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire dic_pkg::set_ctl_t     ctl,
	input  wire logic [LINE_COUNT-1:0] levels,
	input  wire logic [LINE_COUNT-1:0] last_levels,
	input  wire logic [LINE_COUNT-1:0] edge_mode,
	input  wire logic [LINE_COUNT-1:0] active_low,
	input  wire logic [LINE_COUNT-1:0] wdata,
	output logic      [LINE_COUNT-1:0] pend_pre,
	output logic      [LINE_COUNT-1:0] enable_q,
	output logic      [LINE_COUNT-1:0] status_post
);

	logic [LINE_COUNT-1:0] seen_q;
	logic [LINE_COUNT-1:0] edges;
	logic [LINE_COUNT-1:0] level_pend;
	logic [LINE_COUNT-1:0] seen_pre;
	logic [LINE_COUNT-1:0] seen_post;
	logic [LINE_COUNT-1:0] enable_post;

	always_comb begin
		edges = ((levels & ~last_levels) & ~active_low)
			| ((~levels & last_levels) & active_low);
		level_pend = (levels ^ active_low) & ~edge_mode;
		seen_pre = seen_q | edges;
		pend_pre = level_pend | (seen_pre & edge_mode);
		// clear beats an edge detected in the same transfer
		seen_post = ctl.wr_clear ? (seen_pre & ~wdata) : seen_pre;
		enable_post = ctl.wr_mask ? wdata : enable_q;
		status_post = (level_pend | (seen_post & edge_mode)) & enable_post;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= '0;
			enable_q <= '0;
		end else if (ctl.fire) begin
			seen_q <= seen_post;
			enable_q <= enable_post;
		end
	end

endmodule

`default_nettype wire
